// ===== design/pcpu_pkg.sv =====
// shared widths, update codes and arctangent table for the polar/cartesian point unit
package pcpu_pkg;

   // field widths
   localparam int FIELD_W = 20;
   localparam int FUNC_W  = 3;

   // default number of cordic iterations
   localparam int CORDIC_STEPS_DEF = 16;

   // arctangent table: degrees scaled by 2^16, rounded to nearest
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = 5;
   localparam int ATAN_W     = 23;

   // update codes carried in func
   localparam logic [FUNC_W-1:0] FUNC_SET_POLAR  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET_CART   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SET_RADIUS = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SET_ANGLE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SET_X      = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_SET_Y      = 3'd5;

   function automatic logic [ATAN_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      unique case (idx)
         5'd0:    val = 23'd2949120;
         5'd1:    val = 23'd1740967;
         5'd2:    val = 23'd919879;
         5'd3:    val = 23'd466945;
         5'd4:    val = 23'd234379;
         5'd5:    val = 23'd117304;
         5'd6:    val = 23'd58666;
         5'd7:    val = 23'd29335;
         5'd8:    val = 23'd14668;
         5'd9:    val = 23'd7334;
         5'd10:   val = 23'd3667;
         5'd11:   val = 23'd1833;
         5'd12:   val = 23'd917;
         5'd13:   val = 23'd458;
         5'd14:   val = 23'd229;
         5'd15:   val = 23'd115;
         5'd16:   val = 23'd57;
         5'd17:   val = 23'd29;
         5'd18:   val = 23'd14;
         5'd19:   val = 23'd7;
         5'd20:   val = 23'd4;
         5'd21:   val = 23'd2;
         5'd22:   val = 23'd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== design/pcpu_req_if.sv =====
// request channel: update code and coordinates
interface pcpu_req_if
   import pcpu_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic signed [FIELD_W-1:0] coord_a;
   logic signed [FIELD_W-1:0] coord_b;

   modport source (output valid, func, coord_a, coord_b, input ready);
   modport sink   (input valid, func, coord_a, coord_b, output ready);
endinterface

// ===== design/pcpu_rsp_if.sv =====
// response channel: point in polar and cartesian form
interface pcpu_rsp_if
   import pcpu_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] radius_out;
   logic signed [FIELD_W-1:0] angle_out;
   logic signed [FIELD_W-1:0] x_out;
   logic signed [FIELD_W-1:0] y_out;

   modport source (output valid, radius_out, angle_out, x_out, y_out, input ready);
   modport sink   (input valid, radius_out, angle_out, x_out, y_out, output ready);
endinterface

// ===== design/polar_cartesian_point_unit.sv =====
// top level: stored point with one shared cordic datapath for rotation and vectoring
// accept to response: set polar, radius, angle and unused codes run one rotation pass; set x,y runs
// vectoring then rotation (rotation only if zero); set x or y runs rotation, vectoring and rotation
// rotation pass: load angle, wrap/fold, gain multiply, load, iterate, round; vectoring: load, iterate,
// low and high gain multiply, round; one transaction at a time, next request taken in the idle state
// synchronous active-high reset clears the stored radius and angle to zero and drops the response
module polar_cartesian_point_unit
   import pcpu_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   pcpu_req_if.sink        req_ch,
   pcpu_rsp_if.source      rsp_ch
);

   // datapath widths
   localparam int ITER_W    = $clog2(CORDIC_STEPS);
   localparam int LEN_W     = 35;
   localparam int ANG_W     = 26;
   localparam int MUL_A_W   = 22;
   localparam int GAIN_W    = 31;
   localparam int PROD_W    = MUL_A_W + GAIN_W;
   localparam int LO_W      = 17;
   localparam int ACC_W     = PROD_W + LO_W;
   localparam int ROT_SHIFT = 18;
   localparam int OUT_SHIFT = 12;
   localparam int IN_SHIFT  = 12;
   localparam int Z_SHIFT   = 9;
   localparam int ACC_SHIFT = 42;

   // constants
   localparam logic signed [GAIN_W-1:0] GAIN_INV  = 31'sd652032874;
   localparam logic signed [ANG_W-1:0]  DEG90     = 26'sd11520;
   localparam logic signed [ANG_W-1:0]  DEG180    = 26'sd23040;
   localparam logic signed [ANG_W-1:0]  DEG360    = 26'sd46080;
   localparam logic signed [ANG_W-1:0]  WRAP8     = 26'sd368640;
   localparam logic signed [ANG_W-1:0]  WRAP8_LIM = 26'sd345600;
   localparam logic signed [ANG_W-1:0]  START180  = 26'sd11796480;
   localparam logic signed [ANG_W-1:0]  Z_HALF    = 26'sd256;
   localparam logic signed [LEN_W-1:0]  LEN_HALF  = 35'sd2048;
   localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(64'h200_0000_0000);
   localparam logic [ITER_W-1:0]        ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

   // sequencer states
   typedef enum logic [11:0] {
      S_IDLE       = 12'b0000_0000_0001,
      S_ROT_START  = 12'b0000_0000_0010,
      S_NORM       = 12'b0000_0000_0100,
      S_ROT_MUL    = 12'b0000_0000_1000,
      S_ROT_LOAD   = 12'b0000_0001_0000,
      S_ROT_ITER   = 12'b0000_0010_0000,
      S_ROT_DONE   = 12'b0000_0100_0000,
      S_VEC_LOAD   = 12'b0000_1000_0000,
      S_VEC_ITER   = 12'b0001_0000_0000,
      S_VEC_MUL_LO = 12'b0010_0000_0000,
      S_VEC_MUL_HI = 12'b0100_0000_0000,
      S_VEC_DONE   = 12'b1000_0000_0000
   } pcpu_state_type;

   // saturate a wide signed value to the field range
   function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [LEN_W-1:0] v);
      logic [LEN_W-FIELD_W:0] top_bits;
      logic signed [FIELD_W-1:0] res;
      top_bits = v[LEN_W-1:FIELD_W-1];
      priority if (&top_bits || ~|top_bits) begin
         res = v[FIELD_W-1:0];
      end else if (v[LEN_W-1]) begin
         res = {1'b1, {(FIELD_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(FIELD_W-1){1'b1}}};
      end
      return res;
   endfunction

   pcpu_state_type            state_ff, state_in;
   logic [FUNC_W-1:0]         func_ff, func_in;
   logic signed [FIELD_W-1:0] coord_a_ff, coord_a_in;
   logic signed [FIELD_W-1:0] vx_ff, vx_in;
   logic signed [FIELD_W-1:0] vy_ff, vy_in;
   logic signed [FIELD_W-1:0] radius_ff, radius_in;
   logic signed [FIELD_W-1:0] angle_ff, angle_in;
   logic signed [LEN_W-1:0]   x_ff, x_in;
   logic signed [LEN_W-1:0]   y_ff, y_in;
   logic signed [ANG_W-1:0]   z_ff, z_in;
   logic                      neg_ff, neg_in;
   logic                      pre_rot_ff, pre_rot_in;
   logic [ITER_W-1:0]         iter_ff, iter_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  lo_ff, lo_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [FIELD_W-1:0] rsp_radius_ff, rsp_radius_in;
   logic signed [FIELD_W-1:0] rsp_angle_ff, rsp_angle_in;
   logic signed [FIELD_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [FIELD_W-1:0] rsp_y_ff, rsp_y_in;

   logic                      req_fire;
   logic signed [MUL_A_W-1:0] rad_ext;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [PROD_W-1:0]  product;
   logic signed [LEN_W-1:0]   dx;
   logic signed [LEN_W-1:0]   dy;
   logic signed [ANG_W-1:0]   atan_z;
   logic                      sub_dir;
   logic signed [LEN_W-1:0]   x_step;
   logic signed [LEN_W-1:0]   y_step;
   logic signed [ANG_W-1:0]   z_step;
   logic signed [FIELD_W-1:0] cx;
   logic signed [FIELD_W-1:0] cy;
   logic signed [ACC_W-1:0]   acc_sum;
   logic signed [ANG_W-1:0]   z_round;
   logic signed [LEN_W-1:0]   vx_wide;
   logic signed [LEN_W-1:0]   vy_wide;

   // handshake
   assign req_ch.ready      = (state_ff == S_IDLE);
   assign req_fire          = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.radius_out = rsp_radius_ff;
   assign rsp_ch.angle_out  = rsp_angle_ff;
   assign rsp_ch.x_out      = rsp_x_ff;
   assign rsp_ch.y_out      = rsp_y_ff;

   // shared gain multiplier: radius for rotation, low then high half of x for vectoring
   assign rad_ext = MUL_A_W'(radius_ff);
   always_comb begin
      priority if (state_ff == S_VEC_MUL_LO) begin
         mul_a = signed'(MUL_A_W'(x_ff[LO_W-1:0]));
      end else if (state_ff == S_VEC_MUL_HI) begin
         mul_a = MUL_A_W'(signed'(x_ff[LEN_W-1:LO_W]));
      end else begin
         mul_a = neg_ff ? -rad_ext : rad_ext;
      end
   end
   assign product = PROD_W'(mul_a) * PROD_W'(GAIN_INV);

   // shared cordic add/shift unit
   assign dx      = y_ff >>> iter_ff;
   assign dy      = x_ff >>> iter_ff;
   assign atan_z  = signed'(ANG_W'(atan_deg(ATAN_IDX_W'(iter_ff))));
   assign sub_dir = (state_ff == S_ROT_ITER) ? ~z_ff[ANG_W-1] : y_ff[LEN_W-1];
   assign x_step  = sub_dir ? x_ff - dx : x_ff + dx;
   assign y_step  = sub_dir ? y_ff + dy : y_ff - dy;
   assign z_step  = sub_dir ? z_ff - atan_z : z_ff + atan_z;

   // rounding of the cordic results
   assign cx      = sat_field((x_ff + LEN_HALF) >>> OUT_SHIFT);
   assign cy      = sat_field((y_ff + LEN_HALF) >>> OUT_SHIFT);
   assign acc_sum = (ACC_W'(prod_ff) <<< LO_W) + ACC_W'(lo_ff) + ACC_HALF;
   assign z_round = (z_ff + Z_HALF) >>> Z_SHIFT;
   assign vx_wide = LEN_W'(vx_ff) <<< IN_SHIFT;
   assign vy_wide = LEN_W'(vy_ff) <<< IN_SHIFT;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      coord_a_in    = coord_a_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      radius_in     = radius_ff;
      angle_in      = angle_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      neg_in        = neg_ff;
      pre_rot_in    = pre_rot_ff;
      iter_in       = iter_ff;
      prod_in       = prod_ff;
      lo_in         = lo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_radius_in = rsp_radius_ff;
      rsp_angle_in  = rsp_angle_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in    = req_ch.func;
               coord_a_in = req_ch.coord_a;
               pre_rot_in = 1'b0;
               state_in   = S_ROT_START;
               unique case (req_ch.func)
                  FUNC_SET_POLAR: begin
                     radius_in = req_ch.coord_a;
                     angle_in  = req_ch.coord_b;
                  end
                  FUNC_SET_CART: begin
                     vx_in    = req_ch.coord_a;
                     vy_in    = req_ch.coord_b;
                     state_in = S_VEC_LOAD;
                  end
                  FUNC_SET_RADIUS: radius_in = req_ch.coord_a;
                  FUNC_SET_ANGLE:  angle_in  = req_ch.coord_a;
                  FUNC_SET_X, FUNC_SET_Y: pre_rot_in = 1'b1;
                  default: ;
               endcase
            end
         end

         S_ROT_START: begin
            z_in     = ANG_W'(angle_ff);
            state_in = S_NORM;
         end

         // wrap the angle into [-180, 180), then fold into [-90, 90]
         S_NORM: begin
            priority if (z_ff >= WRAP8_LIM) begin
               z_in = z_ff - WRAP8;
            end else if (z_ff >= DEG180) begin
               z_in = z_ff - DEG360;
            end else if (z_ff < -WRAP8_LIM) begin
               z_in = z_ff + WRAP8;
            end else if (z_ff < -DEG180) begin
               z_in = z_ff + DEG360;
            end else begin
               state_in = S_ROT_MUL;
               priority if (z_ff > DEG90) begin
                  z_in   = z_ff - DEG180;
                  neg_in = 1'b1;
               end else if (z_ff < -DEG90) begin
                  z_in   = z_ff + DEG180;
                  neg_in = 1'b1;
               end else begin
                  neg_in = 1'b0;
               end
            end
         end

         S_ROT_MUL: begin
            prod_in  = product;
            z_in     = z_ff <<< Z_SHIFT;
            state_in = S_ROT_LOAD;
         end

         S_ROT_LOAD: begin
            x_in     = LEN_W'(prod_ff >>> ROT_SHIFT);
            y_in     = '0;
            iter_in  = '0;
            state_in = S_ROT_ITER;
         end

         S_ROT_ITER: begin
            x_in    = x_step;
            y_in    = y_step;
            z_in    = z_step;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_LAST) begin
               state_in = S_ROT_DONE;
            end
         end

         // either feed the other coordinate to vectoring or deliver the response
         S_ROT_DONE: begin
            if (pre_rot_ff) begin
               pre_rot_in = 1'b0;
               vx_in      = (func_ff == FUNC_SET_X) ? coord_a_ff : cx;
               vy_in      = (func_ff == FUNC_SET_X) ? cy : coord_a_ff;
               state_in   = S_VEC_LOAD;
            end else if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_radius_in = radius_ff;
               rsp_angle_in  = angle_ff;
               rsp_x_in      = cx;
               rsp_y_in      = cy;
               state_in      = S_IDLE;
            end
         end

         // vectoring setup: a zero vector clears the point, a left half-plane vector is turned by 180 degrees
         S_VEC_LOAD: begin
            iter_in = '0;
            priority if (vx_ff == '0 && vy_ff == '0) begin
               radius_in = '0;
               angle_in  = '0;
               state_in  = S_ROT_START;
            end else if (vx_ff[FIELD_W-1]) begin
               x_in     = -vx_wide;
               y_in     = -vy_wide;
               z_in     = vy_ff[FIELD_W-1] ? -START180 : START180;
               state_in = S_VEC_ITER;
            end else begin
               x_in     = vx_wide;
               y_in     = vy_wide;
               z_in     = '0;
               state_in = S_VEC_ITER;
            end
         end

         S_VEC_ITER: begin
            x_in    = x_step;
            y_in    = y_step;
            z_in    = z_step;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_LAST) begin
               state_in = S_VEC_MUL_LO;
            end
         end

         S_VEC_MUL_LO: begin
            prod_in  = product;
            state_in = S_VEC_MUL_HI;
         end

         S_VEC_MUL_HI: begin
            lo_in    = prod_ff;
            prod_in  = product;
            state_in = S_VEC_DONE;
         end

         S_VEC_DONE: begin
            radius_in = sat_field(LEN_W'(signed'(acc_sum[ACC_W-1:ACC_SHIFT])));
            angle_in  = sat_field(LEN_W'(z_round));
            state_in  = S_ROT_START;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control and stored point
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radius_ff    <= '0;
         angle_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pre_rot_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         angle_ff     <= angle_in;
         rsp_valid_ff <= rsp_valid_in;
         pre_rot_ff   <= pre_rot_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      coord_a_ff    <= coord_a_in;
      vx_ff         <= vx_in;
      vy_ff         <= vy_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      neg_ff        <= neg_in;
      iter_ff       <= iter_in;
      prod_ff       <= prod_in;
      lo_ff         <= lo_in;
      rsp_radius_ff <= rsp_radius_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the polar/cartesian point unit: directed corners, then random updates
module testbench;
   import pcpu_pkg::*;

   localparam int     STEPS        = CORDIC_STEPS_DEF;
   localparam int     ITERATIONS   = (STEPS > 24) ? 24 : STEPS;
   localparam int     RESET_CYCLES = 8;
   localparam int     STALL_LIMIT  = 3000;
   localparam int     DRAIN_CYCLES = 80;
   localparam int     MAX_REPORTS  = 10;
   localparam longint GAIN_INV     = 652032874;
   localparam longint DEG90        = 11520;
   localparam longint DEG180       = 23040;
   localparam longint DEG360       = 46080;
   localparam longint FIELD_HI     = 524287;
   localparam longint FIELD_LO     = -524288;

   // codes that the unit leaves without effect
   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

   localparam logic signed [FIELD_W-1:0] FIELD_MAX = 20'sh7FFFF;
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = 20'sh80000;

   typedef struct {
      logic [FUNC_W-1:0]         func;
      logic signed [FIELD_W-1:0] coord_a;
      logic signed [FIELD_W-1:0] coord_b;
   } point_update_type;

   typedef struct {
      logic signed [FIELD_W-1:0] radius;
      logic signed [FIELD_W-1:0] angle;
      logic signed [FIELD_W-1:0] x;
      logic signed [FIELD_W-1:0] y;
   } point_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pcpu_req_if req_ch ();
   pcpu_rsp_if rsp_ch ();

   polar_cartesian_point_unit #(
      .CORDIC_STEPS (STEPS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // arctangent in degrees scaled by 2^16
   longint arctan_q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   // predicted point state
   longint point_radius = 0;
   longint point_angle  = 0;

   point_view_type expected_points [$];

   int idle_pct        = 0;
   int stall_pct       = 0;
   int mismatches      = 0;
   int results_checked = 0;
   int items_sent      = 0;
   int func_count [8]  = '{default: 0};
   int quiet_cycles    = 0;

   always #2 clock = ~clock;

   function automatic longint clamp_field(input longint v);
      if (v > FIELD_HI) return FIELD_HI;
      if (v < FIELD_LO) return FIELD_LO;
      return v;
   endfunction

   // rotation mode: radius q11.8 and angle q12.7 degrees to saturated x, y
   function automatic void polar_to_cart(input longint r, input longint ang,
                                         output longint xo, output longint yo);
      longint a, rr, x, y, z, dx, dy;
      int     i;
      a  = ang % DEG360;
      rr = r;
      if (a >= DEG180) a -= DEG360;
      if (a < -DEG180) a += DEG360;
      // fold into the right half plane by flipping the radius
      if (a > DEG90) begin
         a -= DEG180;
         rr = -rr;
      end else if (a < -DEG90) begin
         a += DEG180;
         rr = -rr;
      end
      x = (rr * GAIN_INV) >>> 18;
      y = 0;
      z = a * 512;
      for (i = 0; i < ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= arctan_q16[i];
         end else begin
            x += dx;
            y -= dy;
            z += arctan_q16[i];
         end
      end
      xo = clamp_field((x + 2048) >>> 12);
      yo = clamp_field((y + 2048) >>> 12);
   endfunction

   // vectoring mode: x, y q11.8 to radius q11.8 and angle q12.7 degrees
   function automatic void cart_to_polar(input longint x, input longint y,
                                         output longint ro, output longint to);
      longint xs, ys, z, dx, dy;
      int     i;
      if (x == 0 && y == 0) begin
         ro = 0;
         to = 0;
         return;
      end
      xs = x * 4096;
      ys = y * 4096;
      z  = 0;
      // left half plane: turn by 180 degrees first
      if (x < 0) begin
         xs = -xs;
         ys = -ys;
         z  = (y >= 0) ? longint'(180) * 65536 : longint'(-180) * 65536;
      end
      for (i = 0; i < ITERATIONS; i++) begin
         dx = ys >>> i;
         dy = xs >>> i;
         if (ys >= 0) begin
            xs += dx;
            ys -= dy;
            z  += arctan_q16[i];
         end else begin
            xs -= dx;
            ys += dy;
            z  -= arctan_q16[i];
         end
      end
      ro = clamp_field((xs * GAIN_INV + (longint'(1) << 41)) >>> 42);
      to = clamp_field((z + 256) >>> 9);
   endfunction

   // apply one update to the predicted point and return the point it shows
   function automatic point_view_type advance_point(input point_update_type u);
      point_view_type v;
      longint         a, b, cx, cy;
      a = longint'(u.coord_a);
      b = longint'(u.coord_b);
      case (u.func)
         FUNC_SET_POLAR: begin
            point_radius = a;
            point_angle  = b;
         end
         FUNC_SET_CART:   cart_to_polar(a, b, point_radius, point_angle);
         FUNC_SET_RADIUS: point_radius = a;
         FUNC_SET_ANGLE:  point_angle = a;
         FUNC_SET_X: begin
            polar_to_cart(point_radius, point_angle, cx, cy);
            cart_to_polar(a, cy, point_radius, point_angle);
         end
         FUNC_SET_Y: begin
            polar_to_cart(point_radius, point_angle, cx, cy);
            cart_to_polar(cx, a, point_radius, point_angle);
         end
         default: ;
      endcase
      polar_to_cart(point_radius, point_angle, cx, cy);
      v.radius = point_radius[FIELD_W-1:0];
      v.angle  = point_angle[FIELD_W-1:0];
      v.x      = cx[FIELD_W-1:0];
      v.y      = cy[FIELD_W-1:0];
      return v;
   endfunction

   // drive one update transaction and record its expected point once accepted
   task automatic send_update(input logic [FUNC_W-1:0] func,
                              input logic signed [FIELD_W-1:0] a,
                              input logic signed [FIELD_W-1:0] b);
      point_update_type u;
      u.func    = func;
      u.coord_a = a;
      u.coord_b = b;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.func    <= func;
      req_ch.coord_a <= a;
      req_ch.coord_b <= b;
      do @(posedge clock); while (!req_ch.ready);
      expected_points.push_back(advance_point(u));
      items_sent++;
      func_count[func]++;
   endtask

   // random length: full range, near zero, mid range or a corner
   function automatic logic signed [FIELD_W-1:0] pick_length();
      int v;
      case ($urandom_range(3))
         0:       v = $urandom;
         1:       v = int'($urandom_range(8192)) - 4096;
         2:       v = int'($urandom_range(262144)) - 131072;
         default: begin
            case ($urandom_range(4))
               0:       v = int'(FIELD_MAX);
               1:       v = int'(FIELD_MIN);
               2:       v = 1;
               3:       v = -1;
               default: v = 0;
            endcase
         end
      endcase
      return v[FIELD_W-1:0];
   endfunction

   // random angle: full range, within plus or minus one turn, or near a multiple of 90 degrees
   function automatic logic signed [FIELD_W-1:0] pick_angle();
      int v;
      case ($urandom_range(3))
         0:       v = $urandom;
         1, 2:    v = int'($urandom_range(2 * int'(DEG360))) - int'(DEG360);
         default: v = int'($urandom_range(8)) * int'(DEG90) - int'(DEG360)
                      + int'($urandom_range(2)) - 1;
      endcase
      return v[FIELD_W-1:0];
   endfunction

   // receiver side: stall at random per cycle
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // compare each response with the oldest expected point
   always @(posedge clock) begin
      point_view_type want;
      logic           bad;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: r=%0d t=%0d x=%0d y=%0d",
                        rsp_ch.radius_out, rsp_ch.angle_out, rsp_ch.x_out, rsp_ch.y_out);
         end else begin
            want = expected_points.pop_front();
            results_checked++;
            bad = (rsp_ch.radius_out !== want.radius) || (rsp_ch.angle_out !== want.angle) ||
                  (rsp_ch.x_out !== want.x) || (rsp_ch.y_out !== want.y);
            if (bad) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"mismatch on response %0d: expected r=%0d t=%0d x=%0d y=%0d, ",
                            "got r=%0d t=%0d x=%0d y=%0d"},
                           results_checked, want.radius, want.angle, want.x, want.y,
                           rsp_ch.radius_out, rsp_ch.angle_out, rsp_ch.x_out, rsp_ch.y_out);
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d points outstanding",
                  quiet_cycles, expected_points.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // an unused code right after reset shows the cleared point
   task automatic test_reset_point();
      send_update(FUNC_SPARE_6, FIELD_MAX, FIELD_MIN);
   endtask

   // direct sets store values as given, negative radius included
   task automatic test_direct_sets();
      send_update(FUNC_SET_POLAR, FIELD_MAX, FIELD_MIN);
      send_update(FUNC_SET_POLAR, FIELD_MIN, FIELD_MAX);
      send_update(FUNC_SET_RADIUS, 20'sd25600, 20'sd0);
      send_update(FUNC_SET_ANGLE, 20'sd5760, FIELD_MIN);
      send_update(FUNC_SET_RADIUS, -20'sd25600, FIELD_MAX);
      send_update(FUNC_SET_ANGLE, FIELD_MIN, 20'sd0);
   endtask

   // angle wrap and fold around +-90 and +-180 degrees
   task automatic test_angle_wrap();
      send_update(FUNC_SET_RADIUS, 20'sd12800, 20'sd0);
      send_update(FUNC_SET_ANGLE, 20'sd23040, 20'sd0);
      send_update(FUNC_SET_ANGLE, -20'sd23040, 20'sd0);
      send_update(FUNC_SET_ANGLE, 20'sd11521, 20'sd0);
      send_update(FUNC_SET_ANGLE, -20'sd11521, 20'sd0);
      send_update(FUNC_SET_ANGLE, 20'sd46180, 20'sd0);
      send_update(FUNC_SET_ANGLE, -20'sd40000, 20'sd0);
   endtask

   // cartesian sets: zero vector, left half plane, saturating radius
   task automatic test_cartesian();
      send_update(FUNC_SET_CART, 20'sd0, 20'sd0);
      send_update(FUNC_SET_CART, -20'sd2560, 20'sd2560);
      send_update(FUNC_SET_CART, -20'sd2560, -20'sd2560);
      send_update(FUNC_SET_CART, -20'sd2560, 20'sd0);
      send_update(FUNC_SET_CART, FIELD_MAX, FIELD_MAX);
      send_update(FUNC_SET_CART, FIELD_MIN, FIELD_MIN);
   endtask

   // single coordinate updates taking the other one from a saturated point
   task automatic test_single_coord();
      send_update(FUNC_SET_POLAR, FIELD_MAX, 20'sd5760);
      send_update(FUNC_SET_X, FIELD_MIN, FIELD_MAX);
      send_update(FUNC_SET_Y, FIELD_MAX, FIELD_MIN);
      send_update(FUNC_SET_X, 20'sd0, 20'sd0);
      send_update(FUNC_SPARE_7, FIELD_MIN, FIELD_MAX);
   endtask

   // random updates with the given sender idle and receiver stall rates
   task automatic test_random_updates(input int count, input int idle, input int stall);
      logic [FUNC_W-1:0]         f;
      logic signed [FIELD_W-1:0] a, b;
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) begin
         if ($urandom_range(99) < 4)
            f = ($urandom_range(1) == 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
         else
            f = FUNC_W'($urandom_range(FUNC_SET_Y));
         a = (f == FUNC_SET_ANGLE) ? pick_angle() : pick_length();
         case (f)
            FUNC_SET_POLAR: b = pick_angle();
            FUNC_SET_CART:  b = pick_length();
            default:        b = FIELD_W'($urandom);
         endcase
         send_update(f, a, b);
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.func    = FUNC_SET_POLAR;
      req_ch.coord_a = '0;
      req_ch.coord_b = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_point();
      test_direct_sets();
      test_angle_wrap();
      test_cartesian();
      test_single_coord();
      test_random_updates(500, 0, 0);
      test_random_updates(470, 69, 0);
      test_random_updates(470, 0, 69);
      test_random_updates(460, 27, 27);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display({"sent %0d updates (set polar %0d, set cart %0d, radius %0d, angle %0d, ",
                "x %0d, y %0d, unused %0d)"},
               items_sent, func_count[0], func_count[1], func_count[2], func_count[3],
               func_count[4], func_count[5], func_count[6] + func_count[7]);
      $display("checked %0d responses under four idle/stall mixes, %0d mismatches",
               results_checked, mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/pcpu_pkg.sv
design/pcpu_req_if.sv
design/pcpu_rsp_if.sv
design/polar_cartesian_point_unit.sv
tb/testbench.sv
